>>> hw/rtl/dtod_pkg.sv
package dtod_pkg;

  // Field widths fixed by the item format
  localparam int OFF_W   = 32;
  localparam int SEND_W  = 31;
  localparam int CNT_W   = 16;
  localparam int THR_W   = 26;
  localparam int USAGE_W = 2;
  localparam int MUL_W   = 32;
  localparam int DIFF_W  = 26;
  localparam int E_W     = 17;
  localparam int RATE_W  = 20;
  localparam int Q_W     = 30;
  localparam int Z_W     = 39;

  // Usage classes
  localparam logic [USAGE_W-1:0] USAGE_NORMAL = 2'd0;
  localparam logic [USAGE_W-1:0] USAGE_OVER   = 2'd1;
  localparam logic [USAGE_W-1:0] USAGE_UNDER  = 2'd2;

  // Threshold limits, Q10.16 ms
  localparam logic [THR_W-1:0] THR_RESET = 26'd819200;
  localparam logic [THR_W-1:0] THR_MIN   = 26'd393216;
  localparam logic [THR_W-1:0] THR_MAX   = 26'd39321600;
  // Spike margin, 15 ms
  localparam logic [20:0]      ADAPT_MARGIN = 21'd983040;
  // Over-use timer limit, 10 ms
  localparam logic [31:0]      OVER_TIME_LIMIT = 32'd655360;

  // Adaptation rates, Q0.24
  localparam logic [RATE_W-1:0] RATE_DOWN = 20'd654311;
  localparam logic [RATE_W-1:0] RATE_UP   = 20'd145962;
  localparam logic [E_W-1:0]    MAX_ELAPSED_US = 17'd100000;

  // Divide by 1000 on z: q0 = ((z >> 9) * floor(0.512 * 2^32)) >> 32, then one fix-up
  localparam logic [MUL_W-1:0] RECIP_1000 = 32'd2199023255;
  localparam logic [9:0]       DIV_CONST  = 10'd1000;

  // Sample data seen by the overuse detector
  typedef struct packed {
    logic                     above;
    logic                     below;
    logic signed [OFF_W-1:0]  offset;
    logic [SEND_W-1:0]        send;
  } det_in_t;

endpackage

>>> hw/rtl/dtod_mul.sv
module dtod_mul import dtod_pkg::*; (
  input  logic                 clk,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic [2*MUL_W-1:0]   prod
);

  logic [2*MUL_W-1:0] prod_r;

  // Shared unsigned multiplier, one product per cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

>>> hw/rtl/dtod_detect.sv
module dtod_detect import dtod_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd,
  input  det_in_t             det,
  output logic [USAGE_W-1:0]  usage
);

  logic                     ot_valid_r;
  logic [31:0]              ot_ms_r;
  logic [15:0]              ocount_r;
  logic signed [OFF_W-1:0]  prev_off_r;
  logic [USAGE_W-1:0]       usage_r;

  logic [32:0]              ot_sum;
  logic [31:0]              ot_nxt;
  logic [15:0]              cnt_nxt;
  logic                     fire;

  // Timer and count advance while above threshold
  always_comb begin
    ot_sum  = {1'b0, ot_ms_r} + {2'b0, det.send};
    if (!ot_valid_r) begin
      ot_nxt = {2'b0, det.send[SEND_W-1:1]};
    end else if (ot_sum[32]) begin
      ot_nxt = 32'hFFFF_FFFF;
    end else begin
      ot_nxt = ot_sum[31:0];
    end
    cnt_nxt = (ocount_r == 16'hFFFF) ? ocount_r : ocount_r + 16'd1;
    fire    = (ot_nxt > OVER_TIME_LIMIT) && (cnt_nxt > 16'd1) && (det.offset >= prev_off_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ot_valid_r <= 1'b0;
      ot_ms_r    <= '0;
      ocount_r   <= '0;
      prev_off_r <= '0;
      usage_r    <= USAGE_NORMAL;
    end else if (upd) begin
      if (det.above) begin
        ot_valid_r <= 1'b1;
        if (fire) begin
          ot_ms_r  <= '0;
          ocount_r <= '0;
          usage_r  <= USAGE_OVER;
        end else begin
          ot_ms_r  <= ot_nxt;
          ocount_r <= cnt_nxt;
        end
      end else begin
        ot_valid_r <= 1'b0;
        ot_ms_r    <= '0;
        ocount_r   <= '0;
        usage_r    <= det.below ? USAGE_UNDER : USAGE_NORMAL;
      end
      prev_off_r <= det.offset;
    end
  end

  assign usage = usage_r;

endmodule

>>> hw/rtl/delay_trend_overuse_detector_unit.sv
// Delay-trend overuse detector with adaptive threshold. Each input item
// (offset, send gap, delta count, arrival time in us) yields one result item:
// the usage class (normal, overusing, underusing) and the threshold after
// the sample. An item with fewer than two deltas, or a spike sample, goes from
// accept through the classify state to the result; a normal sample runs the
// full sequence of six products through the single shared 32x32 multiplier
// (scaled offset, gap times elapsed time, two halves of the rate product,
// reciprocal estimate of the divide by 1000 and its back-multiply). The input
// is not ready while an item is in work. A finished result sits in an output
// register, so the next item may be taken before it is read. After reset the
// block loads the threshold from cfg_r, which reset sets to THR_RESET; a value
// written by cfg_we is lost at the next reset and never reaches the threshold.
module delay_trend_overuse_detector_unit import dtod_pkg::*; #(
  parameter int MAX_DELTA_SCALE = 60,
  parameter int STAMP_BITS      = 48
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // offset_ms[31:0], send_delta_ms[62:32], delta_count[78:63], now_us[79+:STAMP_BITS]
  input  logic [((79+STAMP_BITS+7)/8)*8-1:0]           in_tdata,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // usage[1:0], threshold_now[27:2]
  output logic [31:0]                                  out_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  input  logic                                         cfg_we,
  input  logic [THR_W-1:0]                             cfg_wdata
);

  localparam int SCALE_W = $clog2(MAX_DELTA_SCALE + 1);
  localparam int MAG_W   = 31 + SCALE_W;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLASS = 4'd1;
  localparam logic [3:0] ST_DE    = 4'd2;
  localparam logic [3:0] ST_RL    = 4'd3;
  localparam logic [3:0] ST_RH    = 4'd4;
  localparam logic [3:0] ST_SUM   = 4'd5;
  localparam logic [3:0] ST_Q     = 4'd6;
  localparam logic [3:0] ST_Q0    = 4'd7;
  localparam logic [3:0] ST_COR   = 4'd8;
  localparam logic [3:0] ST_APPLY = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  // Input fields
  logic signed [OFF_W-1:0]  in_offset;
  logic [SEND_W-1:0]        in_send;
  logic [CNT_W-1:0]         in_count;
  logic [STAMP_BITS-1:0]    in_now;

  assign in_offset = in_tdata[31:0];
  assign in_send   = in_tdata[62:32];
  assign in_count  = in_tdata[78:63];
  assign in_now    = in_tdata[79 +: STAMP_BITS];

  logic [3:0]               state_r;
  logic [3:0]               state_nxt;
  logic                     load_r;
  logic [THR_W-1:0]         cfg_r;
  logic [THR_W-1:0]         thr_r;
  logic                     out_tvalid_r;
  logic [31:0]              out_tdata_r;

  // Latched sample
  logic                     neg_r;
  logic                     few_r;
  logic signed [OFF_W-1:0]  off_r;
  logic [SEND_W-1:0]        send_r;
  logic [STAMP_BITS-1:0]    now_r;

  // Stamp state
  logic                     stamp_valid_r;
  logic [STAMP_BITS-1:0]    last_r;

  // Adaptation datapath registers
  logic [DIFF_W-1:0]        diff_r;
  logic [E_W-1:0]           e_r;
  logic                     down_r;
  logic [26:0]              p1h_r;
  logic [35:0]              lo_r;
  logic [Z_W-1:0]           z_r;
  logic [Q_W-1:0]           q0_r;
  logic [Q_W-1:0]           q_r;

  // Multiplier
  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic [2*MUL_W-1:0]       prod;

  // Detector
  det_in_t                  det;
  logic                     det_upd;
  logic [USAGE_W-1:0]       usage;

  // Classification wires
  logic [SCALE_W-1:0]       scale;
  logic [OFF_W-1:0]         abs_off;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         thr_ext;
  logic                     mag_gt;
  logic                     mag_lt;
  logic                     spike;
  logic [DIFF_W-1:0]        diff;
  logic [STAMP_BITS-1:0]    last_eff;
  logic [STAMP_BITS-1:0]    el_raw;
  logic [E_W-1:0]           el;
  logic [RATE_W-1:0]        rate;
  logic [63:0]              x_sum;
  logic [Z_W-1:0]           rem;
  logic [30:0]              up_sum;
  logic [THR_W-1:0]         thr_new;

  assign in_tready  = (state_r == ST_IDLE) && !load_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Scale and magnitude of the offset
  always_comb begin
    if (in_count < CNT_W'(MAX_DELTA_SCALE)) begin
      scale = in_count[SCALE_W-1:0];
    end else begin
      scale = SCALE_W'(MAX_DELTA_SCALE);
    end
    abs_off = in_offset[OFF_W-1] ? (~in_offset + 32'd1) : in_offset;
  end

  // Compare scaled offset with threshold, elapsed time since last stamp
  always_comb begin
    mag     = prod[MAG_W-1:0];
    thr_ext = {{(MAG_W-THR_W){1'b0}}, thr_r};
    mag_gt  = mag > thr_ext;
    mag_lt  = mag < thr_ext;
    spike   = mag > ({{(MAG_W-THR_W){1'b0}}, thr_r} + {{(MAG_W-21){1'b0}}, ADAPT_MARGIN});
    if (mag_lt) begin
      diff = thr_r - mag[DIFF_W-1:0];
    end else begin
      diff = mag[DIFF_W-1:0] - thr_r;
    end
    last_eff = stamp_valid_r ? last_r : now_r;
    el_raw   = (now_r >= last_eff) ? (now_r - last_eff) : '0;
    if (el_raw > {{(STAMP_BITS-E_W){1'b0}}, MAX_ELAPSED_US}) begin
      el = MAX_ELAPSED_US;
    end else begin
      el = el_raw[E_W-1:0];
    end
  end

  assign det.above = !neg_r && mag_gt;
  assign det.below = neg_r && mag_gt;
  assign det.offset = off_r;
  assign det.send  = send_r;
  assign det_upd   = (state_r == ST_CLASS) && !few_r;

  assign rate = down_r ? RATE_DOWN : RATE_UP;

  // Recombine rate product halves, remainder of the divide, threshold step
  always_comb begin
    x_sum  = {prod[47:0], 16'b0} + {28'b0, lo_r};
    rem    = z_r - prod[Z_W-1:0];
    up_sum = {5'b0, thr_r} + {1'b0, q_r};
    if (!down_r) begin
      thr_new = (up_sum > {5'b0, THR_MAX}) ? THR_MAX : up_sum[THR_W-1:0];
    end else if ({5'b0, thr_r} < ({1'b0, q_r} + {5'b0, THR_MIN})) begin
      thr_new = THR_MIN;
    end else begin
      thr_new = thr_r - q_r[THR_W-1:0];
    end
  end

  // Multiplier operand select
  always_comb begin
    case (state_r)
      ST_IDLE: begin
        mul_a = abs_off;
        mul_b = {{(MUL_W-SCALE_W){1'b0}}, scale};
      end
      ST_DE: begin
        mul_a = {{(MUL_W-DIFF_W){1'b0}}, diff_r};
        mul_b = {{(MUL_W-E_W){1'b0}}, e_r};
      end
      ST_RL: begin
        mul_a = {16'b0, prod[15:0]};
        mul_b = {{(MUL_W-RATE_W){1'b0}}, rate};
      end
      ST_RH: begin
        mul_a = {5'b0, p1h_r};
        mul_b = {{(MUL_W-RATE_W){1'b0}}, rate};
      end
      ST_Q: begin
        mul_a = {2'b0, z_r[Z_W-1:9]};
        mul_b = RECIP_1000;
      end
      ST_Q0: begin
        mul_a = {2'b0, prod[61:32]};
        mul_b = {22'b0, DIV_CONST};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid && in_tready) state_nxt = ST_CLASS;
      ST_CLASS: begin
        if (few_r || spike) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_DE;
        end
      end
      ST_DE:    state_nxt = ST_RL;
      ST_RL:    state_nxt = ST_RH;
      ST_RH:    state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_Q;
      ST_Q:     state_nxt = ST_Q0;
      ST_Q0:    state_nxt = ST_COR;
      ST_COR:   state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_OUT;
      ST_OUT:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      load_r        <= 1'b1;
      cfg_r         <= THR_RESET;
      thr_r         <= THR_RESET;
      out_tvalid_r  <= 1'b0;
      stamp_valid_r <= 1'b0;
      last_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (load_r) begin
        thr_r  <= cfg_r;
        load_r <= 1'b0;
      end else if (state_r == ST_APPLY) begin
        thr_r <= thr_new;
      end
      if ((state_r == ST_CLASS) && !few_r) begin
        stamp_valid_r <= 1'b1;
        last_r        <= now_r;
      end
      // new result loads when none is held or as the held one leaves
      if ((state_r == ST_OUT) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        neg_r  <= in_offset[OFF_W-1];
        few_r  <= in_count < 16'd2;
        off_r  <= in_offset;
        send_r <= in_send;
        now_r  <= in_now;
      end
      ST_CLASS: begin
        diff_r <= diff;
        e_r    <= el;
        down_r <= mag_lt;
      end
      ST_RL:  p1h_r <= prod[42:16];
      ST_RH:  lo_r  <= prod[35:0];
      ST_SUM: z_r   <= x_sum[62:24];
      ST_Q0:  q0_r  <= prod[61:32];
      ST_COR: q_r   <= q0_r + {{(Q_W-1){1'b0}}, (rem >= 39'd1000)};
      ST_OUT: begin
        // held result stays until taken
        if (!out_tvalid_r || out_tready) begin
          out_tdata_r <= {4'b0, thr_r, (few_r ? USAGE_NORMAL : usage)};
        end
      end
      default: begin
      end
    endcase
  end

  dtod_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  dtod_detect u_detect (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (det_upd),
    .det   (det),
    .usage (usage)
  );

endmodule

>>> hw/rtl/dtod_checker.sv
module dtod_checker import dtod_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready
);

  // A held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Not ready in the cycle after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accept");

  // Usage class is one of the three defined codes
  a_usage: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == USAGE_NORMAL) || (out_tdata[1:0] == USAGE_OVER) ||
                   (out_tdata[1:0] == USAGE_UNDER))
    else $error("bad usage code");

  // Reported threshold stays within its clamp range
  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[27:2] >= THR_MIN) && (out_tdata[27:2] <= THR_MAX))
    else $error("threshold out of range");

endmodule

bind delay_trend_overuse_detector_unit dtod_checker u_dtod_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

>>> dv/delay_trend_overuse_detector_unit_test.sv
`timescale 1ns / 100ps

module delay_trend_overuse_detector_unit_test;
  import dtod_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 150;
  localparam int HOLD_AT       = 700;
  localparam int MAX_SHOWN     = 10;
  localparam int PHASE1_ITEMS  = 310;
  localparam int PHASE2_ITEMS  = 310;
  localparam int PHASE3_ITEMS  = 320;
  localparam longint TIMEOUT_NS = 5_000_000;

  localparam longint unsigned STAMP_MASK = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint unsigned STEP_DIV   = 64'd16777216000;
  localparam int              SCALE_CAP  = 60;

  // One sample as it travels on the input bus
  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [SEND_W-1:0] send;
    logic [CNT_W-1:0]  count;
    logic [47:0]       now;
  } sample_t;

  // One usage verdict as it leaves the block
  typedef struct packed {
    logic [USAGE_W-1:0] usage;
    logic [THR_W-1:0]   thr;
  } verdict_t;

  typedef struct packed {
    sample_t            smp;
    logic               known;
    logic [USAGE_W-1:0] usage;
    logic [THR_W-1:0]   thr;
  } plan_row_t;

  typedef enum int {MODE_BAND, MODE_ABOVE, MODE_BELOW, MODE_CLIMB, MODE_SPIKE} drift_mode_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic [127:0]        in_tdata  = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [31:0]         out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [THR_W-1:0]    cfg_wdata  = '0;

  delay_trend_overuse_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Detector state mirror
  logic [THR_W-1:0]   init_thr_reg;
  longint             thr_live;
  bit                 timer_on;
  longint unsigned    timer_ms;
  int unsigned        over_hits;
  longint             prev_off;
  logic [USAGE_W-1:0] usage_now;
  bit                 stamp_seen;
  longint unsigned    stamp_us;

  verdict_t    pending_verdicts[$];
  plan_row_t   plan[$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          errors        = 0;
  int          samples_sent  = 0;
  int          results_seen  = 0;
  int          cfg_writes    = 0;
  int          over_seen     = 0;
  int          under_seen    = 0;
  int          floor_hits    = 0;
  int          ceil_hits     = 0;
  int          hold_left     = 0;
  bit          hold_done     = 1'b0;

  drift_mode_t     run_mode = MODE_BAND;
  int              run_left = 0;
  longint unsigned cur_now  = 64'd5_000_000;

  // Classify one sample and adapt the threshold
  function automatic verdict_t detect_usage(sample_t s);
    longint          off;
    longint          scale;
    longint          m;
    longint          nxt;
    longint unsigned mag;
    longint unsigned thr_u;
    longint unsigned rate;
    longint unsigned dt;
    longint unsigned gap;
    longint unsigned step;
    longint unsigned now;
    verdict_t        v;
    now = s.now;
    if (s.count < 2) begin
      v.usage = USAGE_NORMAL;
      v.thr   = thr_live[THR_W-1:0];
      return v;
    end
    off = $signed(s.offset);
    if (s.count < SCALE_CAP) scale = s.count;
    else scale = SCALE_CAP;
    m = scale * off;

    if (m > thr_live) begin
      if (!timer_on) begin
        timer_on = 1'b1;
        timer_ms = s.send >> 1;
      end else begin
        timer_ms = timer_ms + s.send;
        if (timer_ms > 64'hFFFF_FFFF) timer_ms = 64'hFFFF_FFFF;
      end
      if (over_hits < 65535) over_hits++;
      if (timer_ms > OVER_TIME_LIMIT && over_hits > 1 && off >= prev_off) begin
        timer_ms  = 0;
        over_hits = 0;
        usage_now = USAGE_OVER;
      end
    end else if (m < -thr_live) begin
      timer_on  = 1'b0;
      timer_ms  = 0;
      over_hits = 0;
      usage_now = USAGE_UNDER;
    end else begin
      timer_on  = 1'b0;
      timer_ms  = 0;
      over_hits = 0;
      usage_now = USAGE_NORMAL;
    end
    prev_off = off;

    // Threshold tracks |m| unless the sample is a spike
    mag   = (m < 0) ? -m : m;
    thr_u = thr_live;
    if (!stamp_seen) begin
      stamp_seen = 1'b1;
      stamp_us   = now;
    end
    if (mag <= thr_u + ADAPT_MARGIN) begin
      rate = (mag < thr_u) ? RATE_DOWN : RATE_UP;
      dt   = (now >= stamp_us) ? now - stamp_us : 0;
      if (dt > MAX_ELAPSED_US) dt = MAX_ELAPSED_US;
      gap  = (mag >= thr_u) ? mag - thr_u : thr_u - mag;
      step = (gap * rate * dt) / STEP_DIV;
      nxt  = (mag >= thr_u) ? thr_live + longint'(step) : thr_live - longint'(step);
      if (nxt < longint'(THR_MIN)) nxt = THR_MIN;
      if (nxt > longint'(THR_MAX)) nxt = THR_MAX;
      thr_live = nxt;
    end
    stamp_us = now;

    v.usage = usage_now;
    v.thr   = thr_live[THR_W-1:0];
    return v;
  endfunction

  // Random sample: mostly runs of one drift pattern around the live threshold
  function automatic sample_t draw_sample();
    sample_t     s;
    bit [63:0]   wide;
    int          pick;
    int unsigned thr32;
    longint      scale;
    longint      aim;
    pick  = $urandom_range(99);
    thr32 = thr_live[31:0];
    wide  = {$urandom, $urandom};
    s.offset = $urandom;
    s.send   = SEND_W'($urandom);
    s.count  = CNT_W'($urandom);
    s.now    = wide[47:0];
    // pure noise
    if (pick < 7) return s;
    // too few deltas
    if (pick < 12) begin
      s.count = CNT_W'($urandom_range(1));
      s.now   = cur_now[47:0];
      return s;
    end

    if (run_left == 0) begin
      pick = $urandom_range(99);
      if (pick < 35) run_mode = MODE_BAND;
      else if (pick < 60) run_mode = MODE_ABOVE;
      else if (pick < 75) run_mode = MODE_BELOW;
      else if (pick < 88) run_mode = MODE_CLIMB;
      else run_mode = MODE_SPIKE;
      run_left = (run_mode == MODE_CLIMB) ? $urandom_range(60, 4) : $urandom_range(10, 1);
    end
    run_left--;

    s.count = CNT_W'(($urandom_range(9) == 0) ? $urandom_range(65535, 61) :
                                                $urandom_range(60, 2));
    scale   = (s.count < SCALE_CAP) ? s.count : SCALE_CAP;
    case (run_mode)
      MODE_BAND:  aim = longint'($urandom_range(2 * thr32)) - thr_live;
      MODE_ABOVE: aim = thr_live + 1 + $urandom_range(thr32);
      MODE_BELOW: aim = -(thr_live + 1 + $urandom_range(thr32));
      MODE_CLIMB: aim = thr_live + $urandom_range(ADAPT_MARGIN);
      default: begin
        aim = thr_live + ADAPT_MARGIN + 1 + $urandom_range(32'h3FFF_FFFF);
        if ($urandom_range(1)) aim = -aim;
      end
    endcase
    s.offset = OFF_W'(aim / scale);
    s.send   = SEND_W'(($urandom_range(9) == 0) ? $urandom : $urandom_range(1 << 19));

    // Arrival time: mostly forward, now and then backwards
    if (run_mode != MODE_CLIMB && $urandom_range(24) == 0 && cur_now >= 80000)
      cur_now = cur_now - $urandom_range(80000);
    else if (run_mode == MODE_CLIMB)
      cur_now = (cur_now + $urandom_range(150000, 100000)) & STAMP_MASK;
    else
      cur_now = (cur_now + $urandom_range(60000)) & STAMP_MASK;
    s.now = cur_now[47:0];
    return s;
  endfunction

  task automatic add_row(input logic [31:0] offset, input logic [30:0] send,
                         input logic [15:0] count, input logic [47:0] now,
                         input logic known, input logic [USAGE_W-1:0] usage,
                         input logic [THR_W-1:0] thr);
    plan_row_t r;
    r.smp.offset = offset;
    r.smp.send   = send;
    r.smp.count  = count;
    r.smp.now    = now;
    r.known      = known;
    r.usage      = usage;
    r.thr        = thr;
    plan.push_back(r);
  endtask

  // Offer one item, wait for accept, then record what must come back
  task automatic offer_sample(input sample_t s, input bit known, input verdict_t canned);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, s.now, s.count, s.send, s.offset};
    do @(posedge clk); while (!in_tready);
    v = detect_usage(s);
    pending_verdicts.push_back(known ? canned : v);
    samples_sent++;
  endtask

  task automatic await_idle();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A written start value never reaches the threshold, so the live threshold is untouched
  task automatic set_start_threshold(input logic [THR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    init_thr_reg = val;
    cfg_writes++;
  endtask

  task automatic report(input string what, input longint want, input longint got);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("[%0t] ERROR %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  task automatic run_phase(input int items);
    verdict_t blank;
    blank = '0;
    repeat (items) offer_sample(draw_sample(), 1'b0, blank);
  endtask

  // Result check and receiver back-pressure
  always @(posedge clk) begin : result_check
    verdict_t           want;
    logic [USAGE_W-1:0] got_usage;
    logic [THR_W-1:0]   got_thr;
    got_usage = out_tdata[1:0];
    got_thr   = out_tdata[27:2];
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        report("result with no sample pending, usage", -1, got_usage);
      end else begin
        want = pending_verdicts.pop_front();
        if (got_usage != want.usage) report("usage", want.usage, got_usage);
        if (got_thr != want.thr) report("threshold_now", want.thr, got_thr);
      end
      if (got_usage == USAGE_OVER) over_seen++;
      if (got_usage == USAGE_UNDER) under_seen++;
      if (got_thr == THR_MIN) floor_hits++;
      if (got_thr == THR_MAX) ceil_hits++;
    end

    // long stall once, to back the block up into its input
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still pending", pending_verdicts.size());
    $display("** delay_trend_overuse_detector_unit: FAILED **");
    $finish;
  end

  initial begin : main
    verdict_t canned;
    init_thr_reg = THR_RESET;
    thr_live     = THR_RESET;
    timer_on     = 1'b0;
    timer_ms     = 0;
    over_hits    = 0;
    prev_off     = 0;
    usage_now    = USAGE_NORMAL;
    stamp_seen   = 1'b0;
    stamp_us     = 0;

    // Directed: extremes, each usage class, saturation, time corner cases
    add_row(32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd0, 48'hFFFF_FFFF_FFFF, 1'b1, USAGE_NORMAL,
            THR_RESET);
    add_row(32'h8000_0000, 31'd0, 16'd1, 48'd0, 1'b1, USAGE_NORMAL, THR_RESET);
    // spike above: timer starts at half the gap, no overuse on one hit
    add_row(32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd65535, 48'd1000, 1'b1, USAGE_NORMAL, THR_RESET);
    add_row(32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd60, 48'd2000, 1'b1, USAGE_OVER, THR_RESET);
    add_row(32'h8000_0000, 31'd12345, 16'd2, 48'd3000, 1'b1, USAGE_UNDER, THR_RESET);
    // above threshold keeps the previous class until overuse fires
    add_row(32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd2, 48'd4000, 1'b1, USAGE_UNDER, THR_RESET);
    // falling offset blocks overuse; timer saturates
    add_row(32'h7FFF_FFFE, 31'h7FFF_FFFF, 16'd2, 48'd5000, 1'b0, USAGE_NORMAL, '0);
    add_row(32'h7FFF_FFFD, 31'h7FFF_FFFF, 16'd2, 48'd6000, 1'b0, USAGE_NORMAL, '0);
    add_row(32'h7FFF_FFFD, 31'd0, 16'd2, 48'd7000, 1'b0, USAGE_NORMAL, '0);
    // adaptation down, elapsed cap and floor clamp, backwards time
    add_row(32'd0, 31'd0, 16'd2, 48'd12000, 1'b0, USAGE_NORMAL, '0);
    add_row(32'd0, 31'd0, 16'd2, 48'd1000000, 1'b0, USAGE_NORMAL, '0);
    add_row(32'd4096, 31'd0, 16'd40, 48'd900000, 1'b0, USAGE_NORMAL, '0);
    // just above threshold: a step of one LSB, then climb and overuse
    add_row(32'd196609, 31'd0, 16'd2, 48'd1050000, 1'b0, USAGE_NORMAL, '0);
    add_row(32'd21553, 31'd700000, 16'd60, 48'd1150000, 1'b0, USAGE_NORMAL, '0);
    add_row(32'd21553, 31'd10, 16'd60, 48'd1250000, 1'b0, USAGE_NORMAL, '0);
    // stamp wrap extremes
    add_row(32'd0, 31'd0, 16'd2, 48'hFFFF_FFFF_FFFF, 1'b0, USAGE_NORMAL, '0);
    add_row(32'd0, 31'd0, 16'd2, 48'd0, 1'b0, USAGE_NORMAL, '0);
    add_row(32'hFFFF_0000, 31'd0, 16'd60, 48'd50, 1'b0, USAGE_NORMAL, '0);
    add_row(32'd0, 31'h7FFF_FFFF, 16'd65535, 48'd100, 1'b0, USAGE_NORMAL, '0);
    add_row(32'hFFFF_FFFF, 31'd1, 16'd3, 48'd200, 1'b0, USAGE_NORMAL, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      canned.usage = plan[i].usage;
      canned.thr   = plan[i].thr;
      offer_sample(plan[i].smp, plan[i].known, canned);
    end
    await_idle();
    set_start_threshold(THR_MIN);

    send_idle_pct = 11;
    recv_idle_pct = 49;
    run_phase(PHASE1_ITEMS);
    await_idle();
    set_start_threshold(THR_MAX);

    send_idle_pct = 49;
    recv_idle_pct = 11;
    run_phase(PHASE2_ITEMS);
    await_idle();
    set_start_threshold(THR_W'($urandom_range(THR_MAX, THR_MIN)));

    // no idling; begin with a long climb toward the ceiling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_mode      = MODE_CLIMB;
    run_left      = 60;
    run_phase(PHASE3_ITEMS);
    await_idle();

    if (pending_verdicts.size() != 0) begin
      errors += pending_verdicts.size();
      $display("%0d expected results never arrived", pending_verdicts.size());
    end
    $display("Covered %0d samples, %0d results: %0d overusing, %0d underusing, %0d cfg writes",
             samples_sent, results_seen, over_seen, under_seen, cfg_writes);
    $display("Threshold sat at floor %0d times and at ceiling %0d times; last start value %0d; %0d errors",
             floor_hits, ceil_hits, init_thr_reg, errors);
    if (errors == 0) begin
      $display("** delay_trend_overuse_detector_unit: PASSED **");
    end else begin
      $display("** delay_trend_overuse_detector_unit: FAILED **");
    end
    $finish;
  end

endmodule
